// ===== design/utf8_pkg.sv =====
// Package for the UTF-8 stream decoder: command type between front and back, byte patterns.
package utf8_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // Lead and continuation patterns
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // One command: n_err error results, then optionally one tail result
  typedef struct packed {
    logic [1:0]         n_err;
    logic               has_tail;
    logic               tail_err;
    logic [CpWidth-1:0] cp;
  } cmd_t;

endpackage

// ===== design/utf8_front.sv =====
// Front part: takes each byte, tracks the pending sequence and issues result commands.
module utf8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                cmd_valid_o,
  output utf8_pkg::cmd_t      cmd_o
);
  import utf8_pkg::*;

  logic [1:0]         exp_q, exp_d;
  logic [1:0]         taken_q, taken_d;
  logic [CpWidth-1:0] acc_q, acc_d;
  logic               is_cont;
  logic [CpWidth-1:0] acc_shift;
  cmd_t               cmd;

  assign is_cont   = (in_byte_i & ContMask) == ContPat;
  assign acc_shift = {acc_q[CpWidth-7:0], in_byte_i[5:0]};

  always_comb begin
    exp_d        = exp_q;
    taken_d      = taken_q;
    acc_d        = acc_q;
    cmd.n_err    = 2'd0;
    cmd.has_tail = 1'b0;
    cmd.tail_err = 1'b0;
    cmd.cp       = '0;
    if (exp_q != 2'd0 && is_cont) begin
      acc_d   = acc_shift;
      exp_d   = exp_q - 2'd1;
      taken_d = taken_q + 2'd1;
      if (exp_q == 2'd1) begin
        cmd.has_tail = 1'b1;
        cmd.cp       = acc_shift;
        taken_d      = 2'd0;
        acc_d        = '0;
      end
    end else begin
      // no continuation pending, or one missing: reject every byte taken, then treat as lead
      cmd.n_err = (exp_q != 2'd0) ? taken_q : 2'd0;
      exp_d     = 2'd0;
      taken_d   = 2'd0;
      acc_d     = '0;
      priority if (!in_byte_i[7]) begin
        cmd.has_tail = 1'b1;
        cmd.cp       = {{(CpWidth-8){1'b0}}, in_byte_i};
      end else if ((in_byte_i & Lead2Mask) == Lead2Pat) begin
        acc_d   = {{(CpWidth-5){1'b0}}, in_byte_i[4:0]};
        exp_d   = 2'd1;
        taken_d = 2'd1;
      end else if ((in_byte_i & Lead3Mask) == Lead3Pat) begin
        acc_d   = {{(CpWidth-4){1'b0}}, in_byte_i[3:0]};
        exp_d   = 2'd2;
        taken_d = 2'd1;
      end else if ((in_byte_i & Lead4Mask) == Lead4Pat) begin
        acc_d   = {{(CpWidth-3){1'b0}}, in_byte_i[2:0]};
        exp_d   = 2'd3;
        taken_d = 2'd1;
      end else begin
        cmd.has_tail = 1'b1;
        cmd.tail_err = 1'b1;
      end
    end
  end

  assign cmd_valid_o = in_valid_i && (cmd.n_err != 2'd0 || cmd.has_tail);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= 2'd0;
      taken_q <= 2'd0;
      acc_q   <= '0;
    end else if (in_valid_i) begin
      exp_q   <= exp_d;
      taken_q <= taken_d;
      acc_q   <= acc_d;
    end
  end

  // a pending sequence always has its lead counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 2'd0) |-> (taken_q != 2'd0))
    else $error("pending sequence with no byte taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q == 2'd0) |-> (taken_q == 2'd0))
    else $error("bytes taken with no sequence pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 2'd0) |-> ({1'b0, exp_q} + {1'b0, taken_q} <= 3'd4))
    else $error("sequence longer than four bytes");

endmodule

// ===== design/utf8_queue.sv =====
// Short command queue between front and back.
module utf8_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  utf8_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           rd_valid_o,
  output utf8_pkg::cmd_t rd_data_o
);
  import utf8_pkg::*;

  cmd_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q, count_d;

  assign full_o     = count_q == (QueueAw+1)'(QueueDepth);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    unique case ({wr_i, rd_i})
      2'b10:   count_d = count_q + (QueueAw+1)'(1);
      2'b01:   count_d = count_q - (QueueAw+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> rd_valid_o)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueueAw+1)'(QueueDepth))
    else $error("queue count overrun");

endmodule

// ===== design/utf8_back.sv =====
// Back part: expands each command into result items held in the output register.
module utf8_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  utf8_pkg::cmd_t               cmd_i,
  output logic                         cmd_take_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [utf8_pkg::CpWidth-1:0] code_point_o,
  output logic                         is_error_o,
  output logic                         last_o
);
  import utf8_pkg::*;

  logic busy_q;
  cmd_t cur_q;
  logic popped;
  logic final_res;
  logic load;

  assign popped    = pop_i && busy_q;
  // final result of the current command
  assign final_res = (cur_q.n_err == 2'd0) || (cur_q.n_err == 2'd1 && !cur_q.has_tail);
  assign load      = !busy_q || (popped && final_res);
  assign cmd_take_o = load && cmd_valid_i;

  assign empty_o      = !busy_q;
  assign code_point_o = (cur_q.n_err != 2'd0) ? '0 : cur_q.cp;
  assign is_error_o   = (cur_q.n_err != 2'd0) ? 1'b1 : cur_q.tail_err;
  assign last_o       = final_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cur_q <= cmd_i;
    end else if (popped && !final_res) begin
      cur_q.n_err <= cur_q.n_err - 2'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_q.n_err != 2'd0 || cur_q.has_tail))
    else $error("held command carries no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (popped && !final_res) |=> !empty_o)
    else $error("command dropped before its last result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !last_o) |-> is_error_o)
    else $error("non-final result that is not an error");

endmodule

// ===== design/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front, command queue and back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   bytes in | push / full        | in_byte_i[7:0]
//   results  | empty / pop        | code_point_o[20:0], is_error_o, last_o
//
// A byte is taken when push meets !full; its results (zero to four) leave the back
// one per cycle while pop is held. Plain text thus runs at one item per cycle;
// a missing continuation gives up to four results, absorbed by the four-entry queue.
// Reset clears sequence state, queue count and busy flag, not cur_q; no clearing pass.
// full follows the queue alone, so bytes are taken while a result waits to be popped.
module utf8_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [utf8_pkg::CpWidth-1:0] code_point_o,
  output logic                         is_error_o,
  output logic                         last_o
);
  import utf8_pkg::*;

  logic in_valid;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_data;
  logic q_take;

  assign in_valid = push && !full;

  utf8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_byte_i   (in_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  utf8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cmd_valid),
    .wr_data_i  (cmd),
    .full_o     (full),
    .rd_i       (q_take),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data)
  );

  utf8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_data),
    .cmd_take_o   (q_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .code_point_o (code_point_o),
    .is_error_o   (is_error_o),
    .last_o       (last_o)
  );

endmodule
